/* sv/brfifo_pkg.sv */
// shared types, codes and defaults for the broadcast ring fifo
package brfifo_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int READERS_DEF    = 4;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int WORD_W = 32;
    localparam int RID_W  = 2;
    localparam int FREE_W = 7;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                     func;
        logic signed [WORD_W-1:0] push_data;
        logic [RID_W-1:0]         reader_id;
    } cmd_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] pop_data;
        logic [1:0]               status;
        logic [FREE_W-1:0]        free_slots;
    } rsp_item_t;

endpackage

/* sv/brfifo_if.sv */
// valid/ready channel carrying one payload per transaction
interface brfifo_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/broadcast_ring_fifo.sv */
// broadcast ring fifo: one writer, several readers that each read every word
// usage:
//   cmd channel carries transactions with func (push or pop), push_data and
//   reader_id; rsp channel returns one transaction per command with pop_data,
//   status and free_slots
//   a push stores the word and makes it unread for every reader; a pop by one
//   reader returns the oldest word that reader has not yet read
//   a slot is released once no reader still holds every stored word unread
//   push when full answers status full; pop with nothing unread (or a reader
//   id of READERS or above) answers status empty; both leave state untouched
// timing:
//   the slot store is a synchronous ram with a registered read; a command
//   is decoded and its control state updated in the cycle it is accepted, the
//   ram read is registered alongside the middle stage, and the response
//   register follows; one command per cycle is taken as long as the
//   response side keeps up
// reset: pointers and unread counts clear, all DEPTH slots free; the store
//   itself is not cleared (no reader can reach an unwritten slot)
// stall: when rsp is not taken the response register holds, the middle stage
//   fills, and cmd.ready drops until the response moves on
module broadcast_ring_fifo #(
    parameter int DEPTH      = brfifo_pkg::DEPTH_DEF,
    parameter int READERS    = brfifo_pkg::READERS_DEF,
    parameter int DATA_WIDTH = brfifo_pkg::DATA_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    brfifo_if.sink   cmd,
    brfifo_if.source rsp
);
    import brfifo_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;

    // slot store, read data registered
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // control state
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg [READERS];
    logic [PW-1:0] rp_next [READERS];
    logic [CW-1:0] unread_reg [READERS];
    logic [CW-1:0] unread_next [READERS];
    logic [CW-1:0] free_reg, free_next;

    // middle stage: waits for the ram read
    logic          s1_valid_reg;
    logic          s1_pop_ok_reg;
    status_t       s1_status_reg;
    logic [CW-1:0] s1_free_reg;

    // response register
    logic      out_valid_reg;
    rsp_item_t out_item_reg;

    logic          cmd_fire;
    logic          s1_adv;
    logic          rid_ok;
    logic [RW-1:0] rid;
    logic          wr_en;
    logic          rd_en;
    logic          pop_ok;
    status_t       status_c;
    logic [CW-1:0] stored;

    // handshake
    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign cmd.ready = !s1_valid_reg || s1_adv;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_item_reg;

    assign rid    = RW'(cmd.data.reader_id);
    assign rid_ok = 32'(cmd.data.reader_id) < 32'(READERS);
    assign stored = CW'(DEPTH) - free_reg;

    // command decode and control state update
    always_comb
    begin
        logic hold;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        unread_next = unread_reg;
        free_next   = free_reg;
        status_c    = ST_DONE;
        pop_ok      = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        hold        = 1'b0;
        if (cmd_fire)
        begin
            if (cmd.data.func == FUNC_PUSH)
            begin
                if (free_reg == '0)
                begin
                    status_c = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wp_next   = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    free_next = free_reg - 1'b1;
                    for (int i = 0; i < READERS; i++)
                    begin
                        unread_next[i] = unread_reg[i] + 1'b1;
                    end
                end
            end
            else
            begin
                if (!rid_ok || unread_reg[rid] == '0)
                begin
                    status_c = ST_EMPTY;
                end
                else
                begin
                    pop_ok           = 1'b1;
                    rd_en            = 1'b1;
                    rp_next[rid]     = (rp_reg[rid] == PW'(DEPTH - 1)) ? '0
                                                                       : rp_reg[rid] + 1'b1;
                    unread_next[rid] = unread_reg[rid] - 1'b1;
                    // a slot stays held while any reader still has all words unread
                    for (int i = 0; i < READERS; i++)
                    begin
                        if (unread_next[i] == stored)
                        begin
                            hold = 1'b1;
                        end
                    end
                    if (!hold && free_reg < CW'(DEPTH))
                    begin
                        free_next = free_reg + 1'b1;
                    end
                end
            end
        end
    end

    // slot store: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= DATA_WIDTH'($unsigned(cmd.data.push_data));
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rp_reg[rid]];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            free_reg <= CW'(DEPTH);
            for (int i = 0; i < READERS; i++)
            begin
                rp_reg[i]     <= '0;
                unread_reg[i] <= '0;
            end
        end
        else
        begin
            wp_reg     <= wp_next;
            free_reg   <= free_next;
            rp_reg     <= rp_next;
            unread_reg <= unread_next;
        end
    end

    // middle stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // middle stage payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_pop_ok_reg <= pop_ok;
            s1_status_reg <= status_c;
            s1_free_reg   <= free_next;
        end
    end

    // response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // response payload, pop data taken straight from the ram read register
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_item_reg.pop_data   <= s1_pop_ok_reg ? $signed(WORD_W'(rd_data_reg)) : '0;
            out_item_reg.status     <= s1_status_reg;
            out_item_reg.free_slots <= FREE_W'(s1_free_reg);
        end
    end

    // free count never exceeds the ring depth
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CW'(DEPTH))
        else $error("free count above depth");

    // no reader has more unread words than are stored
    for (genvar g = 0; g < READERS; g++)
    begin : g_unread_chk
        a_unread_bound: assert property (@(posedge clk) disable iff (!rst_n)
            unread_reg[g] <= stored)
            else $error("unread count above stored words");
    end

    // a refused push leaves the ring full
    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.data.func == FUNC_PUSH && free_reg == '0) |=> free_reg == '0)
        else $error("refused push changed free count");

    // every accepted command occupies the middle stage next cycle
    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> s1_valid_reg)
        else $error("accepted command lost");

endmodule
